// ===== src/tepkt_pkg.sv =====
`timescale 1ns / 1ps

package tepkt_pkg;

  localparam int CODE_W  = 8;
  localparam int VOL_W   = 6;
  localparam int DUR_W   = 16;
  localparam int TS_W    = 32;
  localparam int MS_W    = 32;
  localparam int LEN_W   = 16;
  localparam int PKTS_W  = 16;

  localparam int REPEAT_END_DEF = 3;

  localparam logic [MS_W-1:0]   GAP_MS             = 32'd100;
  localparam logic [TS_W-1:0]   SEG_MAX            = 32'h0000_ffff;
  localparam logic [PKTS_W-1:0] PACKET_SAMPLES_RST = 16'd160;
  // 8 samples per millisecond.
  localparam int                SAMPLES_SHIFT      = 3;

  typedef struct packed {
    logic              frame_empty;
    logic [TS_W-1:0]   frame_rtp_ts;
    logic [MS_W-1:0]   now_ms;
    logic              tone_pending;
    logic [CODE_W-1:0] tone_key;
    logic [LEN_W-1:0]  tone_length_ms;
    logic [VOL_W-1:0]  tone_level;
  } in_item_t;

  // Everything the beat sequencer needs for the results of one frame.
  typedef struct packed {
    logic              packet;
    logic              ended;
    logic              marker;
    logic [CODE_W-1:0] code;
    logic [VOL_W-1:0]  volume;
    logic [DUR_W-1:0]  dur_a;
    logic [TS_W-1:0]   ts_a;
    logic [DUR_W-1:0]  dur_b;
    logic [TS_W-1:0]   ts_b;
    logic              through;
    logic              taken;
  } event_desc_t;

endpackage

// ===== src/tepkt_in_if.sv =====
`timescale 1ns / 1ps

interface tepkt_in_if;
  import tepkt_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_empty;
  logic [TS_W-1:0]   frame_rtp_ts;
  logic [MS_W-1:0]   now_ms;
  logic              tone_pending;
  logic [CODE_W-1:0] tone_key;
  logic [LEN_W-1:0]  tone_length_ms;
  logic [VOL_W-1:0]  tone_level;

  modport source (
    output valid, frame_empty, frame_rtp_ts, now_ms, tone_pending, tone_key,
           tone_length_ms, tone_level,
    input  ready
  );

  modport sink (
    input  valid, frame_empty, frame_rtp_ts, now_ms, tone_pending, tone_key,
           tone_length_ms, tone_level,
    output ready
  );
endinterface

// ===== src/tepkt_out_if.sv =====
`timescale 1ns / 1ps

interface tepkt_out_if;
  import tepkt_pkg::*;

  logic              valid;
  logic              ready;
  logic              packet_valid;
  logic [CODE_W-1:0] event_code;
  logic              end_flag;
  logic [VOL_W-1:0]  event_volume;
  logic [DUR_W-1:0]  event_duration;
  logic [TS_W-1:0]   event_timestamp;
  logic              marker;
  logic              audio_through;
  logic              tone_taken;
  logic              last;

  modport source (
    output valid, packet_valid, event_code, end_flag, event_volume, event_duration,
           event_timestamp, marker, audio_through, tone_taken, last,
    input  ready
  );

  modport sink (
    input  valid, packet_valid, event_code, end_flag, event_volume, event_duration,
           event_timestamp, marker, audio_through, tone_taken, last,
    output ready
  );
endinterface

// ===== src/telephone_event_packet_scheduler.sv =====
`timescale 1ns / 1ps
// Telephone-event packet scheduler.
// in_ch takes one beat per audio frame tick: frame RTP timestamp, wall time in ms,
// the empty-frame flag and the head of the tone queue. out_ch gives the result
// beats of that frame in order, the final one marked by last. A frame gives one
// beat when no event packet is due, one packet beat normally, REPEAT_END beats
// for an ending packet, and twice that when a long event splits its segment, so
// between 1 and 2*REPEAT_END beats.
// A frame waits in the input register, where its packets are worked out and the
// event state is updated; it is loaded into the result register once that is free,
// and its first result beat is presented from there.
// The result register sends one beat per cycle while out_ch.ready is high, and the
// next frame is taken as the last beat of the current one leaves, so the block
// takes one frame per cycle while each frame gives a single beat and the receiver
// is ready, and a frame of more beats holds the next one back until its last leaves.
// cfg_wr_en writes packet_samples, the minimum timestamp gap between packets on
// empty frames; write it only while the block is idle.
// Synchronous reset clears the event state, sets packet_samples to 160 and
// drops out_ch.valid. When the receiver stalls, the current beat holds and the
// input register fills, after which in_ch.ready falls.

module telephone_event_packet_scheduler #(
  parameter int REPEAT_END = tepkt_pkg::REPEAT_END_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tepkt_in_if.sink                     in_ch,
  tepkt_out_if.source                  out_ch,
  input  logic                         cfg_wr_en,
  input  logic [tepkt_pkg::PKTS_W-1:0] cfg_wr_data
);
  import tepkt_pkg::*;

  localparam int BEAT_W = (2 * REPEAT_END > 1) ? $clog2(2 * REPEAT_END) : 1;

  in_item_t          in_item;
  event_desc_t       desc;
  logic              load;
  logic              emit_free;
  logic [BEAT_W-1:0] grp_last;
  logic [BEAT_W-1:0] final_idx;

  assign in_item.frame_empty    = in_ch.frame_empty;
  assign in_item.frame_rtp_ts   = in_ch.frame_rtp_ts;
  assign in_item.now_ms         = in_ch.now_ms;
  assign in_item.tone_pending   = in_ch.tone_pending;
  assign in_item.tone_key       = in_ch.tone_key;
  assign in_item.tone_length_ms = in_ch.tone_length_ms;
  assign in_item.tone_level     = in_ch.tone_level;

  tepkt_core #(
    .REPEAT_END (REPEAT_END)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .emit_free   (emit_free),
    .load        (load),
    .desc        (desc),
    .grp_last    (grp_last),
    .final_idx   (final_idx)
  );

  tepkt_emit #(
    .REPEAT_END (REPEAT_END)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .desc      (desc),
    .grp_last  (grp_last),
    .final_idx (final_idx),
    .emit_free (emit_free),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/tepkt_core.sv =====
`timescale 1ns / 1ps

module tepkt_core #(
  parameter int REPEAT_END = tepkt_pkg::REPEAT_END_DEF,
  localparam int BEAT_W = (2 * REPEAT_END > 1) ? $clog2(2 * REPEAT_END) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tepkt_pkg::in_item_t         in_item,
  input  logic                        cfg_wr_en,
  input  logic [tepkt_pkg::PKTS_W-1:0] cfg_wr_data,
  input  logic                        emit_free,
  output logic                        load,
  output tepkt_pkg::event_desc_t      desc,
  output logic [BEAT_W-1:0]           grp_last,
  output logic [BEAT_W-1:0]           final_idx
);
  import tepkt_pkg::*;

  logic              item_v_r;
  in_item_t          item_r;
  logic [PKTS_W-1:0] pkt_samples_r;

  logic              active_r,    active_nxt;
  logic              fpd_r,       fpd_nxt;
  logic [TS_W-1:0]   seg_r,       seg_nxt;
  logic [CODE_W-1:0] code_r,      code_nxt;
  logic [VOL_W-1:0]  vol_r,       vol_nxt;
  logic [TS_W-1:0]   rem_r,       rem_nxt;
  logic [MS_W-1:0]   end_ms_r,    end_ms_nxt;
  logic [TS_W-1:0]   last_sent_r, last_sent_nxt;

  logic              take;
  logic              act;
  logic [TS_W-1:0]   seg;
  logic [TS_W-1:0]   rem;
  logic              fpd;
  logic              throttled;
  logic              send_ok;
  logic [TS_W-1:0]   dur;
  logic [TS_W-1:0]   dur_b;
  logic              ended;
  logic              send;
  logic              split;
  logic              packet;
  logic [BEAT_W-1:0] rep_m1;

  assign load     = item_v_r & emit_free;
  assign in_ready = ~item_v_r | emit_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_samples_r <= PACKET_SAMPLES_RST;
    end else if (cfg_wr_en) begin
      pkt_samples_r <= cfg_wr_data;
    end
  end

  always_comb begin
    take = ~active_r & item_r.tone_pending & ((item_r.now_ms - end_ms_r) > GAP_MS);
    act  = active_r | take;
    seg  = take ? item_r.frame_rtp_ts : seg_r;
    rem  = take ? {{(TS_W - LEN_W - SAMPLES_SHIFT){1'b0}}, item_r.tone_length_ms,
                   {SAMPLES_SHIFT{1'b0}}}
                : rem_r;
    fpd  = take ? 1'b0 : fpd_r;

    throttled = item_r.frame_empty &
                ({{(TS_W - PKTS_W){1'b0}}, pkt_samples_r} >
                 (item_r.frame_rtp_ts - last_sent_r));
    send_ok   = act & ~throttled;
    dur       = item_r.frame_rtp_ts - seg;
    dur_b     = dur - SEG_MAX;
    ended     = ~(rem > dur);
    // A running event whose duration is still zero sends nothing.
    send      = ended | (dur != '0);
    split     = dur > SEG_MAX;
    packet    = send_ok & send;

    active_nxt    = act;
    fpd_nxt       = fpd;
    seg_nxt       = seg;
    rem_nxt       = rem;
    code_nxt      = take ? item_r.tone_key   : code_r;
    vol_nxt       = take ? item_r.tone_level : vol_r;
    end_ms_nxt    = end_ms_r;
    last_sent_nxt = last_sent_r;

    if (send_ok) begin
      last_sent_nxt = item_r.frame_rtp_ts;
      if (ended) begin
        active_nxt = 1'b0;
        end_ms_nxt = item_r.now_ms;
      end
      if (send) begin
        if (split) begin
          seg_nxt = item_r.frame_rtp_ts;
          rem_nxt = rem - SEG_MAX;
        end else begin
          fpd_nxt = 1'b1;
        end
      end
    end

    desc.packet  = packet;
    desc.ended   = packet & ended;
    desc.marker  = packet & ~split & ~fpd;
    desc.code    = packet ? code_nxt : '0;
    desc.volume  = packet ? vol_nxt  : '0;
    desc.dur_a   = !packet ? '0 : (split ? SEG_MAX[DUR_W-1:0] : dur[DUR_W-1:0]);
    desc.ts_a    = packet ? seg : '0;
    desc.dur_b   = packet ? dur_b[DUR_W-1:0] : '0;
    desc.ts_b    = packet ? item_r.frame_rtp_ts : '0;
    desc.through = ~act;
    desc.taken   = take;

    rep_m1    = ended ? BEAT_W'(REPEAT_END - 1) : '0;
    grp_last  = rep_m1;
    if (!packet) begin
      final_idx = '0;
    end else if (split) begin
      final_idx = ended ? BEAT_W'(2 * REPEAT_END - 1) : BEAT_W'(1);
    end else begin
      final_idx = rep_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      fpd_r       <= 1'b0;
      seg_r       <= '0;
      code_r      <= '0;
      vol_r       <= '0;
      rem_r       <= '0;
      end_ms_r    <= '0;
      last_sent_r <= '0;
    end else if (load) begin
      active_r    <= active_nxt;
      fpd_r       <= fpd_nxt;
      seg_r       <= seg_nxt;
      code_r      <= code_nxt;
      vol_r       <= vol_nxt;
      rem_r       <= rem_nxt;
      end_ms_r    <= end_ms_nxt;
      last_sent_r <= last_sent_nxt;
    end
  end

endmodule

// ===== src/tepkt_emit.sv =====
`timescale 1ns / 1ps

module tepkt_emit #(
  parameter int REPEAT_END = tepkt_pkg::REPEAT_END_DEF,
  localparam int BEAT_W = (2 * REPEAT_END > 1) ? $clog2(2 * REPEAT_END) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  tepkt_pkg::event_desc_t desc,
  input  logic [BEAT_W-1:0]      grp_last,
  input  logic [BEAT_W-1:0]      final_idx,
  output logic                   emit_free,
  tepkt_out_if.source            out_ch
);
  import tepkt_pkg::*;

  logic              valid_r;
  event_desc_t       desc_r;
  logic [BEAT_W-1:0] grp_last_r;
  logic [BEAT_W-1:0] final_r;
  logic [BEAT_W-1:0] beat_r;
  logic              final_beat;
  logic              in_grp_b;

  assign final_beat = beat_r == final_r;
  assign emit_free  = ~valid_r | (out_ch.ready & final_beat);
  // Beats past the first group belong to the restarted segment.
  assign in_grp_b   = beat_r > grp_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
    end else if (valid_r && out_ch.ready) begin
      if (final_beat) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r     <= desc;
      grp_last_r <= grp_last;
      final_r    <= final_idx;
    end
  end

  assign out_ch.valid           = valid_r;
  assign out_ch.packet_valid    = desc_r.packet;
  assign out_ch.event_code      = desc_r.code;
  assign out_ch.end_flag        = desc_r.ended;
  assign out_ch.event_volume    = desc_r.volume;
  assign out_ch.event_duration  = in_grp_b ? desc_r.dur_b : desc_r.dur_a;
  assign out_ch.event_timestamp = in_grp_b ? desc_r.ts_b  : desc_r.ts_a;
  assign out_ch.marker          = desc_r.marker & ~in_grp_b;
  assign out_ch.audio_through   = desc_r.through;
  assign out_ch.tone_taken      = desc_r.taken;
  assign out_ch.last            = final_beat;

endmodule

// ===== src/tepkt_checker.sv =====
`timescale 1ns / 1ps

module tepkt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         packet_valid,
  input logic [tepkt_pkg::CODE_W-1:0] event_code,
  input logic                         end_flag,
  input logic [tepkt_pkg::DUR_W-1:0]  event_duration,
  input logic                         marker,
  input logic                         audio_through,
  input logic                         last
);

  // A stalled beat keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_duration) && $stable(last))
    else $error("result beat changed while stalled");

  // A beat without a packet is always the only beat of its frame.
  a_nopkt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !packet_valid |-> last)
    else $error("non-packet beat is not the final beat");

  // Packet fields are clear on a beat without a packet.
  a_nopkt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !packet_valid |-> event_code == '0 && !end_flag && !marker
                                   && event_duration == '0)
    else $error("packet fields set on a non-packet beat");

  // A frame that goes to the audio path carries no event packet.
  a_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && audio_through |-> !packet_valid)
    else $error("packet beat on an audio frame");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind telephone_event_packet_scheduler tepkt_checker u_tepkt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .packet_valid   (out_ch.packet_valid),
  .event_code     (out_ch.event_code),
  .end_flag       (out_ch.end_flag),
  .event_duration (out_ch.event_duration),
  .marker         (out_ch.marker),
  .audio_through  (out_ch.audio_through),
  .last           (out_ch.last)
);

// ===== dv/telephone_event_checker.sv =====
`timescale 1ns / 1ps

module telephone_event_checker #(
  parameter int REPEAT_END = tepkt_pkg::REPEAT_END_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tepkt_in_if                          in_ch,
  tepkt_out_if                         out_ch,
  input  logic                         cfg_wr_en,
  input  logic [tepkt_pkg::PKTS_W-1:0] cfg_wr_data,
  output int                           fault_count,
  output int                           beats_outstanding,
  output int                           frames_seen,
  output int                           beats_seen,
  output int                           packets_seen
);
  import tepkt_pkg::*;

  typedef struct packed {
    logic              packet_valid;
    logic [CODE_W-1:0] event_code;
    logic              end_flag;
    logic [VOL_W-1:0]  event_volume;
    logic [DUR_W-1:0]  event_duration;
    logic [TS_W-1:0]   event_timestamp;
    logic              marker;
    logic              audio_through;
    logic              tone_taken;
    logic              last;
  } result_beat_t;

  // Predicted scheduler state.
  logic [PKTS_W-1:0] min_pkt_gap;
  bit                tone_on;
  bit                first_sent;
  logic [TS_W-1:0]   seg_ts;
  logic [CODE_W-1:0] cur_code;
  logic [VOL_W-1:0]  cur_vol;
  logic [31:0]       samples_left;
  logic [MS_W-1:0]   tone_end_ms;
  logic [TS_W-1:0]   last_pkt_ts;

  result_beat_t expected_beats[$];
  result_beat_t frame_beats[$];

  int faults  = 0;
  int frames  = 0;
  int beats   = 0;
  int packets = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    faults++;
  endtask

  task automatic check_field(input string name, input logic [TS_W-1:0] got,
                             input logic [TS_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h on result beat %0d",
                                name, got, want, beats));
    end
  endtask

  // An ending packet goes out REPEAT_END times, any other packet once.
  function automatic void add_packets(input bit ended, input logic [DUR_W-1:0] dur,
                                      input logic [TS_W-1:0] ts, input bit mark,
                                      input bit taken);
    result_beat_t b;
    b                 = '0;
    b.packet_valid    = 1'b1;
    b.event_code      = cur_code;
    b.end_flag        = ended;
    b.event_volume    = cur_vol;
    b.event_duration  = dur;
    b.event_timestamp = ts;
    b.marker          = mark;
    b.tone_taken      = taken;
    repeat (ended ? REPEAT_END : 1) frame_beats.push_back(b);
  endfunction

  function automatic void predict_frame_beats(input in_item_t f);
    logic [MS_W-1:0] wall_gap;
    logic [TS_W-1:0] since_last;
    logic [31:0]     dur;
    bit              taken;
    bit              through;
    bit              ended;
    bit              send;
    result_beat_t    b;

    frame_beats.delete();
    taken    = 1'b0;
    wall_gap = f.now_ms - tone_end_ms;
    if (!tone_on && f.tone_pending && wall_gap > GAP_MS) begin
      seg_ts       = f.frame_rtp_ts;
      first_sent   = 1'b0;
      cur_code     = f.tone_key;
      cur_vol      = f.tone_level;
      samples_left = 32'(f.tone_length_ms) << SAMPLES_SHIFT;
      tone_on      = 1'b1;
      taken        = 1'b1;
    end
    through = !tone_on;

    since_last = f.frame_rtp_ts - last_pkt_ts;
    if (tone_on && !(f.frame_empty && 32'(min_pkt_gap) > since_last)) begin
      dur         = f.frame_rtp_ts - seg_ts;
      ended       = 1'b0;
      send        = 1'b1;
      last_pkt_ts = f.frame_rtp_ts;
      if (samples_left > dur) begin
        // An event that is still running sends nothing at zero duration.
        if (dur == 0) send = 1'b0;
      end else begin
        ended       = 1'b1;
        tone_on     = 1'b0;
        tone_end_ms = f.now_ms;
      end
      if (send) begin
        if (dur > SEG_MAX) begin
          // The old segment is closed at full length and a new one starts here.
          add_packets(ended, SEG_MAX[DUR_W-1:0], seg_ts, 1'b0, taken);
          seg_ts       = f.frame_rtp_ts;
          dur          = dur - SEG_MAX;
          samples_left = samples_left - SEG_MAX;
          add_packets(ended, dur[DUR_W-1:0], seg_ts, 1'b0, taken);
        end else begin
          add_packets(ended, dur[DUR_W-1:0], seg_ts, !first_sent, taken);
          first_sent = 1'b1;
        end
      end
    end

    if (frame_beats.size() == 0) begin
      b               = '0;
      b.audio_through = through;
      b.tone_taken    = taken;
      frame_beats.push_back(b);
    end
    b      = frame_beats.pop_back();
    b.last = 1'b1;
    frame_beats.push_back(b);
    foreach (frame_beats[i]) expected_beats.push_back(frame_beats[i]);
  endfunction

  always @(posedge clk) begin : watch
    in_item_t     frame;
    result_beat_t got;
    result_beat_t want;
    if (!rst_n) begin
      min_pkt_gap  = PACKET_SAMPLES_RST;
      tone_on      = 1'b0;
      first_sent   = 1'b0;
      seg_ts       = '0;
      cur_code     = '0;
      cur_vol      = '0;
      samples_left = '0;
      tone_end_ms  = '0;
      last_pkt_ts  = '0;
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) min_pkt_gap = cfg_wr_data;

      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        frame.frame_empty    = in_ch.frame_empty;
        frame.frame_rtp_ts   = in_ch.frame_rtp_ts;
        frame.now_ms         = in_ch.now_ms;
        frame.tone_pending   = in_ch.tone_pending;
        frame.tone_key       = in_ch.tone_key;
        frame.tone_length_ms = in_ch.tone_length_ms;
        frame.tone_level     = in_ch.tone_level;
        predict_frame_beats(frame);
        frames++;
      end

      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.packet_valid    = out_ch.packet_valid;
        got.event_code      = out_ch.event_code;
        got.end_flag        = out_ch.end_flag;
        got.event_volume    = out_ch.event_volume;
        got.event_duration  = out_ch.event_duration;
        got.event_timestamp = out_ch.event_timestamp;
        got.marker          = out_ch.marker;
        got.audio_through   = out_ch.audio_through;
        got.tone_taken      = out_ch.tone_taken;
        got.last            = out_ch.last;
        beats++;
        if (got.packet_valid === 1'b1) packets++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with no frame outstanding",
                                    beats));
        end else begin
          want = expected_beats.pop_front();
          check_field("packet_valid",    got.packet_valid,    want.packet_valid);
          check_field("event_code",      got.event_code,      want.event_code);
          check_field("end_flag",        got.end_flag,        want.end_flag);
          check_field("event_volume",    got.event_volume,    want.event_volume);
          check_field("event_duration",  got.event_duration,  want.event_duration);
          check_field("event_timestamp", got.event_timestamp, want.event_timestamp);
          check_field("marker",          got.marker,          want.marker);
          check_field("audio_through",   got.audio_through,   want.audio_through);
          check_field("tone_taken",      got.tone_taken,      want.tone_taken);
          check_field("last",            got.last,            want.last);
        end
      end
    end

    // Published a step late so that the stimulus never races these counts.
    fault_count       <= faults;
    beats_outstanding <= expected_beats.size();
    frames_seen       <= frames;
    beats_seen        <= beats;
    packets_seen      <= packets;
  end

endmodule

// ===== dv/telephone_event_packet_scheduler_tb.sv =====
`timescale 1ns / 1ps

module telephone_event_packet_scheduler_tb;
  import tepkt_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int REPEAT_END  = REPEAT_END_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_LEN   = 80;
  localparam int PHASE_LEN   = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [PKTS_W-1:0] cfg_wr_data;

  int fault_count;
  int beats_outstanding;
  int frames_seen;
  int beats_seen;
  int packets_seen;

  int tx_idle_pct;
  int rx_idle_pct;
  int stall_asks   = 0;
  int stall_served = 0;
  int cycle_count  = 0;

  logic [TS_W-1:0]   cap_t;
  logic [MS_W-1:0]   now_t;
  logic [PKTS_W-1:0] mid_gap;

  tepkt_in_if  in_ch ();
  tepkt_out_if out_ch ();

  telephone_event_packet_scheduler #(
    .REPEAT_END (REPEAT_END)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  telephone_event_checker #(
    .REPEAT_END (REPEAT_END)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .fault_count       (fault_count),
    .beats_outstanding (beats_outstanding),
    .frames_seen       (frames_seen),
    .beats_seen        (beats_seen),
    .packets_seen      (packets_seen)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[telephone_event_packet_scheduler] ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off whenever one is asked for.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asks != stall_served) begin
        stall_served = stall_served + 1;
        out_ch.ready <= 1'b0;
        repeat (STALL_LEN - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Valid is left high after a beat so that back-to-back frames never toggle it.
  task automatic send_frame(input in_item_t f);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.frame_empty    <= f.frame_empty;
    in_ch.frame_rtp_ts   <= f.frame_rtp_ts;
    in_ch.now_ms         <= f.now_ms;
    in_ch.tone_pending   <= f.tone_pending;
    in_ch.tone_key       <= f.tone_key;
    in_ch.tone_length_ms <= f.tone_length_ms;
    in_ch.tone_level     <= f.tone_level;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic tick(input bit empty, input logic [TS_W-1:0] cap,
                      input logic [MS_W-1:0] now, input bit pending,
                      input logic [CODE_W-1:0] key, input logic [LEN_W-1:0] len,
                      input logic [VOL_W-1:0] level);
    in_item_t f;
    f.frame_empty    = empty;
    f.frame_rtp_ts   = cap;
    f.now_ms         = now;
    f.tone_pending   = pending;
    f.tone_key       = key;
    f.tone_length_ms = len;
    f.tone_level     = level;
    send_frame(f);
  endtask

  // The block is idle once every result has come back; a frame always gives one.
  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_packet_samples(input logic [PKTS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly a plausible frame stream with a running timestamp and wall clock;
  // large jumps end or split long events, and a few frames are pure noise.
  task automatic make_frame(output in_item_t f);
    int pick;
    int len_pick;
    pick     = $urandom_range(0, 99);
    len_pick = $urandom_range(0, 99);
    f.frame_empty  = ($urandom_range(0, 99) < 30);
    f.tone_pending = ($urandom_range(0, 99) < 35);
    f.tone_key     = CODE_W'($urandom);
    f.tone_level   = VOL_W'($urandom);
    if (len_pick < 65) f.tone_length_ms = LEN_W'($urandom_range(20, 300));
    else if (len_pick < 80) f.tone_length_ms = LEN_W'($urandom_range(0, 19));
    else if (len_pick < 90) f.tone_length_ms = LEN_W'($urandom);
    else f.tone_length_ms = '1;
    if (pick < 8) begin
      f.frame_rtp_ts = $urandom;
      f.now_ms       = $urandom;
    end else begin
      if (pick < 70) cap_t += TS_W'(80 * $urandom_range(1, 3));
      else if (pick < 88) cap_t += TS_W'($urandom_range(0, 400));
      else if (pick < 92) cap_t += TS_W'($urandom_range(65536, 200000));
      else if (pick < 96) cap_t += TS_W'($urandom_range(500000, 1000000));
      now_t += MS_W'($urandom_range(10, 20));
      f.frame_rtp_ts = cap_t;
      f.now_ms       = now_t;
    end
  endtask

  task automatic run_random_frames(input int count, input int stall_at);
    in_item_t f;
    for (int i = 0; i < count; i++) begin
      if (i == stall_at) stall_asks <= stall_asks + 1;
      make_frame(f);
      send_frame(f);
    end
  endtask

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.frame_empty    <= 1'b0;
    in_ch.frame_rtp_ts   <= '0;
    in_ch.now_ms         <= '0;
    in_ch.tone_pending   <= 1'b0;
    in_ch.tone_key       <= '0;
    in_ch.tone_length_ms <= '0;
    in_ch.tone_level     <= '0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    rst_n                <= 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 8;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames with packet_samples at its reset value.
    tick(0, 32'd1000, 32'd1000, 0, 8'h00, 16'd0, 6'd0);
    tick(1, 32'd1000, 32'd50, 1, 8'h11, 16'd40, 6'd10);        // too soon after reset
    tick(0, 32'd2000, 32'd2000, 1, 8'hff, 16'd40, 6'd63);      // taken, zero duration
    tick(0, 32'd2160, 32'd2020, 1, 8'h22, 16'd5, 6'd1);        // first packet, marked
    tick(1, 32'd2200, 32'd2025, 0, 8'h00, 16'd0, 6'd0);        // throttled empty frame
    tick(1, 32'd2320, 32'd2040, 0, 8'h00, 16'd0, 6'd0);        // ending, repeated
    tick(0, 32'd2480, 32'd2140, 1, 8'h33, 16'd10, 6'd5);       // gap of exactly 100 ms
    tick(0, 32'd2640, 32'd2141, 1, 8'h00, 16'd0, 6'd0);        // zero length ends at once
    tick(0, 32'hffff_0000, 32'd2400, 1, 8'ha5, 16'hffff, 6'd21);
    tick(0, 32'h0001_0170, 32'd2420, 0, 8'h00, 16'd0, 6'd0);   // split, still running
    tick(1, 32'h0001_017a, 32'd2430, 0, 8'h00, 16'd0, 6'd0);
    tick(0, 32'h0001_0210, 32'd2440, 0, 8'h00, 16'd0, 6'd0);
    tick(0, 32'h000a_2930, 32'd2480, 0, 8'h00, 16'd0, 6'd0);   // split and ending
    tick(0, 32'h000a_2994, 32'd2475, 1, 8'h80, 16'd1, 6'd32);  // wall clock wraps
    tick(1, 32'h000a_2a5c, 32'd2490, 0, 8'h00, 16'd0, 6'd0);
    tick(1, 32'd5, 32'd3000, 1, 8'h44, 16'd3, 6'd7);           // timestamp goes backwards
    tick(1, 32'd10, 32'd3010, 0, 8'h00, 16'd0, 6'd0);
    tick(0, 32'hffff_fff0, 32'd3020, 1, 8'h55, 16'd9, 6'd9);   // huge duration, short tone
    drain_frames();

    cap_t = $urandom;
    now_t = $urandom;

    write_packet_samples('0);
    run_random_frames(PHASE_LEN, -1);
    drain_frames();

    // Long hold-off on the result side while frames keep coming.
    write_packet_samples('1);
    run_random_frames(PHASE_LEN, 5);
    drain_frames();

    mid_gap = PKTS_W'($urandom_range(1, 400));
    write_packet_samples(mid_gap);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_frames(PHASE_LEN, -1);
    drain_frames();

    tx_idle_pct = 8;
    rx_idle_pct = 8;
    write_packet_samples(PACKET_SAMPLES_RST);
    run_random_frames(PHASE_LEN / 2, -1);
    drain_frames();
    run_random_frames(PHASE_LEN / 2, 3);
    drain_frames();
    repeat (10) @(posedge clk);

    $display("Run covered %0d frames and %0d result beats, %0d of them event packets.",
             frames_seen, beats_seen, packets_seen);
    $display("packet_samples took 160, 0, 65535, %0d and 160 again, with result stalls.",
             mid_gap);
    if (fault_count == 0) begin
      $display("[telephone_event_packet_scheduler] OK");
    end else begin
      $display("[telephone_event_packet_scheduler] ERROR");
    end
    $finish;
  end

endmodule
